[hw/rtl/kdj_pkg.sv]
// kdj_pkg: shared widths, types and codes for the kdj stochastic oscillator
// used by kdj_window, kdj_divider and kdj_stochastic_oscillator; no dependencies

package kdj_pkg;

   // price and window sizing
   localparam int PRICE_W   = 32;
   localparam int WIN_DEPTH = 64;
   localparam int WIN_AW    = $clog2(WIN_DEPTH);
   localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

   // result sizing, q7.16 percent
   localparam int LINE_W   = 23;
   localparam int J_W      = 26;
   localparam int RSV_FULL = 6553600;

   // shared divider sizing
   localparam int DVD_W    = PRICE_W + LINE_W;
   localparam int KD_DVD_W = 31;
   localparam int KD_PAD   = DVD_W - KD_DVD_W;
   localparam int ITER_W   = $clog2(DVD_W + 1);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int WDAYS_W    = 7;
   localparam int PERIOD_W   = 8;

   typedef logic [PRICE_W-1:0] price_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_DAYS = 2'd0,
      CSR_K_PERIOD    = 2'd1,
      CSR_D_PERIOD    = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_GO,
      ST_SCAN_WAIT,
      ST_RSV,
      ST_RSV_MUL,
      ST_RSV_GO,
      ST_RSV_WAIT,
      ST_K_MUL,
      ST_K_ADD,
      ST_K_GO,
      ST_K_WAIT,
      ST_D_MUL,
      ST_D_ADD,
      ST_D_GO,
      ST_D_WAIT,
      ST_J,
      ST_OUT
   } state_type;

   // window control from the sequencer
   typedef struct packed {
      logic              push;
      price_type         high;
      price_type         low;
      logic              scan_start;
      logic [FILL_W-1:0] scan_len;
   } win_ctl_type;

   // window scan status back to the sequencer
   typedef struct packed {
      logic      done;
      price_type highest;
      price_type lowest;
   } win_stat_type;

   // divider request and response
   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      price_type         divisor;
      logic [ITER_W-1:0] iters;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

[hw/rtl/kdj_stochastic_oscillator.sv]
// kdj_stochastic_oscillator: top level, config registers, sequencer and result register
// depends on kdj_pkg, kdj_window and kdj_divider

// One request carries a period's high, low and close price; one response carries
// K, D, J and the window_full and flat_range flags. Below, n is the window length in
// use: window_days, with 0 taken as 1 and anything above 64 taken as 64. While fewer
// than n periods have been seen the response is all zero and goes from the idle
// state through ST_OUT into the output register once that register is free. Once
// the window is full a request runs a serial scan through the price memories (one
// entry per cycle), then three passes of the shared one-bit-per-cycle divider (55
// steps for RSV, 31 each for K and D), each set up by the sequencer and started from
// its GO state, then ST_J for J and ST_OUT for the hand-off. When RSV is clipped
// (flat or inverted range, close at or below the lowest low, or at or above the
// highest high) the RSV pass is skipped. The block takes no request while it works;
// a finished response waits in an output register, so the next request may be taken
// before it is read, and the block then holds its request side off once that next
// response is also finished and the first is still unread. The price memories need
// no clearing after reset.

module kdj_stochastic_oscillator
   import kdj_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: [31:0] high_price, [63:32] low_price, [95:64] close_price
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*PRICE_W-1:0]  req_tdata,
   // response: [22:0] k_line, [45:23] d_line, [71:46] j_line
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,
   // response flags: [0] window_full, [1] flat_range
   output logic [1:0]            rsp_tuser,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type state_ff, state_in;

   logic [WDAYS_W-1:0]  wdays_ff;
   logic [PERIOD_W-1:0] kper_ff, dper_ff;

   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   n_eff;
   logic [PERIOD_W-1:0] m1, m2;
   price_type           close_ff, close_in;
   price_type           num_ff, num_in;
   price_type           den_ff, den_in;
   logic                flat_ff, flat_in;
   logic                full_ff, full_in;
   logic [LINE_W-1:0]   rsv_ff, rsv_in;
   logic [KD_DVD_W-1:0] prod_ff, prod_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   price_type           dsr_ff, dsr_in;
   logic [ITER_W-1:0]   iters_ff, iters_in;
   logic [LINE_W-1:0]   k_ff, k_in;
   logic [LINE_W-1:0]   d_ff, d_in;
   logic [J_W-1:0]      j_ff, j_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LINE_W-1:0]   rsp_k_ff, rsp_k_in;
   logic [LINE_W-1:0]   rsp_d_ff, rsp_d_in;
   logic [J_W-1:0]      rsp_j_ff, rsp_j_in;
   logic                rsp_full_ff, rsp_full_in;
   logic                rsp_flat_ff, rsp_flat_in;

   logic                accept;
   logic                div_start;
   win_ctl_type         win_ctl;
   win_stat_type        win_stat;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // configuration registers, writes always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wdays_ff <= WDAYS_W'(9);
         kper_ff  <= PERIOD_W'(3);
         dper_ff  <= PERIOD_W'(3);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_DAYS: wdays_ff <= csr_data[WDAYS_W-1:0];
            CSR_K_PERIOD:    kper_ff  <= csr_data[PERIOD_W-1:0];
            CSR_D_PERIOD:    dper_ff  <= csr_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // effective window length and smoothing divisors
   always_comb begin
      if (wdays_ff == '0)                    n_eff = FILL_W'(1);
      else if (wdays_ff > WDAYS_W'(WIN_DEPTH)) n_eff = FILL_W'(WIN_DEPTH);
      else                                   n_eff = FILL_W'(wdays_ff);
      m1 = (kper_ff == '0) ? PERIOD_W'(1) : kper_ff;
      m2 = (dper_ff == '0) ? PERIOD_W'(1) : dper_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      close_in     = close_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      flat_in      = flat_ff;
      full_in      = full_ff;
      rsv_in       = rsv_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      dsr_in       = dsr_ff;
      iters_in     = iters_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      j_in         = j_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_k_in     = rsp_k_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_j_in     = rsp_j_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_flat_in  = rsp_flat_ff;

      win_ctl.push       = accept;
      win_ctl.high       = req_tdata[PRICE_W-1:0];
      win_ctl.low        = req_tdata[2*PRICE_W-1:PRICE_W];
      win_ctl.scan_start = 1'b0;
      win_ctl.scan_len   = n_eff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               close_in = req_tdata[3*PRICE_W-1:2*PRICE_W];
               fill_in  = (fill_ff == FILL_W'(WIN_DEPTH)) ? fill_ff : fill_ff + 1'b1;
               if (fill_in >= n_eff) begin
                  full_in  = 1'b1;
                  state_in = ST_SCAN_GO;
               end else begin
                  // window not yet full: zero result, smoothing restarts
                  full_in  = 1'b0;
                  flat_in  = 1'b0;
                  k_in     = '0;
                  d_in     = '0;
                  j_in     = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_SCAN_GO: begin
            win_ctl.scan_start = 1'b1;
            state_in           = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            if (win_stat.done) state_in = ST_RSV;
         end
         // range checks and the clipped cases of rsv
         ST_RSV: begin
            flat_in = (win_stat.highest <= win_stat.lowest);
            num_in  = close_ff - win_stat.lowest;
            den_in  = win_stat.highest - win_stat.lowest;
            if (win_stat.highest <= win_stat.lowest || close_ff <= win_stat.lowest) begin
               rsv_in   = '0;
               state_in = ST_K_MUL;
            end else if (close_ff >= win_stat.highest) begin
               rsv_in   = LINE_W'(RSV_FULL);
               state_in = ST_K_MUL;
            end else begin
               state_in = ST_RSV_MUL;
            end
         end
         // scale by full range, 100 << 16 = (64 + 32 + 4) << 16
         ST_RSV_MUL: begin
            dvd_in   = (DVD_W'(num_ff) << 22) + (DVD_W'(num_ff) << 21)
                     + (DVD_W'(num_ff) << 18);
            dsr_in   = den_ff;
            iters_in = ITER_W'(DVD_W);
            state_in = ST_RSV_GO;
         end
         ST_RSV_GO: begin
            div_start = 1'b1;
            state_in  = ST_RSV_WAIT;
         end
         ST_RSV_WAIT: begin
            if (div_rsp.done) begin
               rsv_in   = div_rsp.quotient[LINE_W-1:0];
               state_in = ST_K_MUL;
            end
         end
         // k smoothing
         ST_K_MUL: begin
            prod_in  = KD_DVD_W'(m1 - 1'b1) * KD_DVD_W'(k_ff);
            state_in = ST_K_ADD;
         end
         ST_K_ADD: begin
            dvd_in   = {KD_DVD_W'(rsv_ff) + prod_ff, {KD_PAD{1'b0}}};
            dsr_in   = PRICE_W'(m1);
            iters_in = ITER_W'(KD_DVD_W);
            state_in = ST_K_GO;
         end
         ST_K_GO: begin
            div_start = 1'b1;
            state_in  = ST_K_WAIT;
         end
         ST_K_WAIT: begin
            if (div_rsp.done) begin
               k_in     = div_rsp.quotient[LINE_W-1:0];
               state_in = ST_D_MUL;
            end
         end
         // d smoothing
         ST_D_MUL: begin
            prod_in  = KD_DVD_W'(m2 - 1'b1) * KD_DVD_W'(d_ff);
            state_in = ST_D_ADD;
         end
         ST_D_ADD: begin
            dvd_in   = {KD_DVD_W'(k_ff) + prod_ff, {KD_PAD{1'b0}}};
            dsr_in   = PRICE_W'(m2);
            iters_in = ITER_W'(KD_DVD_W);
            state_in = ST_D_GO;
         end
         ST_D_GO: begin
            div_start = 1'b1;
            state_in  = ST_D_WAIT;
         end
         ST_D_WAIT: begin
            if (div_rsp.done) begin
               d_in     = div_rsp.quotient[LINE_W-1:0];
               state_in = ST_J;
            end
         end
         // j = 3k - 2d
         ST_J: begin
            j_in = J_W'({k_ff}) + J_W'({k_ff, 1'b0}) - J_W'({d_ff, 1'b0});
            state_in = ST_OUT;
         end
         // hand the result to the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_k_in     = k_ff;
               rsp_d_in     = d_ff;
               rsp_j_in     = j_ff;
               rsp_full_in  = full_ff;
               rsp_flat_in  = flat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         k_ff         <= '0;
         d_ff         <= '0;
         j_ff         <= '0;
         full_ff      <= 1'b0;
         flat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         k_ff         <= k_in;
         d_ff         <= d_in;
         j_ff         <= j_in;
         full_ff      <= full_in;
         flat_ff      <= flat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      close_ff    <= close_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rsv_ff      <= rsv_in;
      prod_ff     <= prod_in;
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
      iters_ff    <= iters_in;
      rsp_k_ff    <= rsp_k_in;
      rsp_d_ff    <= rsp_d_in;
      rsp_j_ff    <= rsp_j_in;
      rsp_full_ff <= rsp_full_in;
      rsp_flat_ff <= rsp_flat_in;
   end

   // shared divider request
   assign div_req.start    = div_start;
   assign div_req.dividend = dvd_ff;
   assign div_req.divisor  = dsr_ff;
   assign div_req.iters    = iters_ff;

   kdj_window u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .stat  (win_stat)
   );

   kdj_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_j_ff, rsp_d_ff, rsp_k_ff};
   assign rsp_tuser  = {rsp_flat_ff, rsp_full_ff};

endmodule

[hw/rtl/kdj_window.sv]
// kdj_window: high and low price windows in memory, write pointer and the
// serial highest-high / lowest-low scan; depends on kdj_pkg

module kdj_window
   import kdj_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  win_ctl_type  ctl,
   output win_stat_type stat
);

   price_type high_mem [WIN_DEPTH];
   price_type low_mem  [WIN_DEPTH];

   logic [WIN_AW-1:0] wp_ff, wp_in;
   logic [WIN_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] issue_left_ff, issue_left_in;
   logic [FILL_W-1:0] cmp_left_ff, cmp_left_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              first_ff, first_in;
   logic              done_ff, done_in;
   price_type         highest_ff, highest_in;
   price_type         lowest_ff, lowest_in;
   price_type         hi_rd_ff, lo_rd_ff;
   logic              rd_en;

   // wrap-around step helpers
   function automatic logic [WIN_AW-1:0] ptr_dec(input logic [WIN_AW-1:0] p);
      ptr_dec = (p == '0) ? WIN_AW'(WIN_DEPTH - 1) : p - 1'b1;
   endfunction

   function automatic logic [WIN_AW-1:0] ptr_inc(input logic [WIN_AW-1:0] p);
      ptr_inc = (p == WIN_AW'(WIN_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign rd_en = (issue_left_ff != '0);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         high_mem[wp_ff] <= ctl.high;
         low_mem[wp_ff]  <= ctl.low;
      end
      if (rd_en) begin
         hi_rd_ff <= high_mem[rd_ptr_ff];
         lo_rd_ff <= low_mem[rd_ptr_ff];
      end
   end

   // scan sequencing and running extremes
   always_comb begin
      wp_in         = ctl.push ? ptr_inc(wp_ff) : wp_ff;
      rd_ptr_in     = rd_ptr_ff;
      issue_left_in = issue_left_ff;
      cmp_left_in   = cmp_left_ff;
      rd_vld_in     = 1'b0;
      first_in      = first_ff;
      done_in       = 1'b0;
      highest_in    = highest_ff;
      lowest_in     = lowest_ff;

      if (ctl.scan_start) begin
         rd_ptr_in     = ptr_dec(wp_ff);
         issue_left_in = ctl.scan_len;
         cmp_left_in   = ctl.scan_len;
         first_in      = 1'b1;
      end else begin
         // issue one read a cycle, newest entry first
         if (rd_en) begin
            rd_ptr_in     = ptr_dec(rd_ptr_ff);
            issue_left_in = issue_left_ff - 1'b1;
            rd_vld_in     = 1'b1;
         end
         // fold in the entry read last cycle
         if (rd_vld_ff) begin
            if (first_ff || hi_rd_ff > highest_ff) highest_in = hi_rd_ff;
            if (first_ff || lo_rd_ff < lowest_ff) lowest_in = lo_rd_ff;
            first_in    = 1'b0;
            cmp_left_in = cmp_left_ff - 1'b1;
            if (cmp_left_ff == FILL_W'(1)) done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         issue_left_ff <= '0;
         cmp_left_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         first_ff      <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         issue_left_ff <= issue_left_in;
         cmp_left_ff   <= cmp_left_in;
         rd_vld_ff     <= rd_vld_in;
         first_ff      <= first_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      highest_ff <= highest_in;
      lowest_ff  <= lowest_in;
   end

   assign stat.done    = done_ff;
   assign stat.highest = highest_ff;
   assign stat.lowest  = lowest_ff;

   // scan bookkeeping checks
   a_done_after_issue: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (issue_left_ff == '0))
      else $error("scan finished with reads still to issue");

   a_read_has_slot: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (cmp_left_ff != '0))
      else $error("read data arrived with no compare pending");

   a_cmp_covers_issue: assert property (@(posedge clock) disable iff (reset)
      cmp_left_ff >= issue_left_ff)
      else $error("more reads to issue than compares pending");

endmodule

[hw/rtl/kdj_divider.sv]
// kdj_divider: shared restoring divider, one quotient bit per cycle
// depends on kdj_pkg

module kdj_divider
   import kdj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   price_type         rem_ff, rem_in;
   price_type         dsr_ff, dsr_in;
   logic [DVD_W-1:0]  q_ff, q_in;
   logic [PRICE_W:0]  shift;
   logic [PRICE_W:0]  diff;
   logic              ge;

   // one restoring step
   always_comb begin
      shift = {rem_ff, q_ff[DVD_W-1]};
      diff  = shift - {1'b0, dsr_ff};
      ge    = (shift >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.iters;
         rem_in  = '0;
         dsr_in  = req.divisor;
         q_in    = req.dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[PRICE_W-1:0] : shift[PRICE_W-1:0];
         q_in   = {q_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule
